### rtl/jnc_pkg.sv
`timescale 1ns / 1ps

package jnc_pkg;

   // Stack geometry
   localparam int STACK_DEPTH = 32;
   localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
   localparam int LIM_W       = (DEPTH_W > 6) ? DEPTH_W : 6;

   // Field and register widths
   localparam int BYTE_W      = 8;
   localparam int COUNT_W     = 21;
   localparam int MAXD_W      = 6;
   localparam int OPEN_W      = 6;
   localparam int CSR_DATA_W  = 21;
   localparam int CSR_INDEX_W = 1;

   localparam logic [COUNT_W-1:0] COUNT_MAX     = {COUNT_W{1'b1}};
   localparam logic [COUNT_W-1:0] MAX_BYTES_RST = COUNT_W'(1024 * 1024);
   localparam logic [MAXD_W-1:0]  MAX_DEPTH_RST = MAXD_W'(32);

   // Delimiter bytes
   localparam logic [BYTE_W-1:0] CH_LBRACE = 8'h7B;
   localparam logic [BYTE_W-1:0] CH_LBRACK = 8'h5B;
   localparam logic [BYTE_W-1:0] CH_RBRACE = 8'h7D;
   localparam logic [BYTE_W-1:0] CH_RBRACK = 8'h5D;
   localparam logic [BYTE_W-1:0] CH_QUOTE  = 8'h22;
   localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;

   // Container kinds held in the stack cells
   localparam logic KIND_BRACE = 1'b0;
   localparam logic KIND_BRACK = 1'b1;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_BYTES = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_DEPTH = 1'b1;

   typedef enum logic [1:0] {
      ERR_NONE     = 2'd0,
      ERR_DEEP     = 2'd1,
      ERR_MISMATCH = 2'd2
   } err_type;

   typedef enum logic [2:0] {
      VERDICT_OK       = 3'd0,
      VERDICT_TOO_BIG  = 3'd1,
      VERDICT_TOO_DEEP = 3'd2,
      VERDICT_MISMATCH = 3'd3,
      VERDICT_UNTERM   = 3'd4
   } verdict_type;

   // Shift command sent along the cell row
   typedef struct packed {
      logic push;
      logic pop;
      logic kind;
   } stack_op_type;

   // One result item
   typedef struct packed {
      logic                  done_res;
      verdict_type           verdict;
      logic                  error_seen;
      logic [OPEN_W-1:0]     open_count;
   } result_type;

endpackage

### rtl/jnc_if.sv
`timescale 1ns / 1ps

// Input byte channel
interface jnc_req_if;
   logic                       valid;
   logic                       ready;
   logic [jnc_pkg::BYTE_W-1:0] data_byte;
   logic                       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// Result channel
interface jnc_rsp_if;
   logic                       valid;
   logic                       ready;
   logic                       done_res;
   logic [2:0]                 verdict;
   logic                       error_seen;
   logic [jnc_pkg::OPEN_W-1:0] open_count;

   modport source (output valid, output done_res, output verdict, output error_seen,
                   output open_count, input ready);
   modport sink   (input valid, input done_res, input verdict, input error_seen,
                   input open_count, output ready);
endinterface

### rtl/jnc_cell.sv
`timescale 1ns / 1ps

// One stack level: takes the kind from the level above on a push and from
// the level below on a pop.
module jnc_cell (
   input  logic                  clock,
   input  jnc_pkg::stack_op_type op,
   input  logic                  from_upper,
   input  logic                  from_lower,
   output logic                  kind
);

   logic kind_ff;
   logic kind_in;

   always_comb begin
      kind_in = kind_ff;
      if (op.push) begin
         kind_in = from_upper;
      end else if (op.pop) begin
         kind_in = from_lower;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
   end

   assign kind = kind_ff;

endmodule

### rtl/jnc_ctrl.sv
`timescale 1ns / 1ps

// Per-document scan state: string/escape flags, depth, byte count and the
// first structural error. Drives the cell row and forms each result item.
module jnc_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [jnc_pkg::BYTE_W-1:0]    data_byte,
   input  logic                          last_byte,
   input  logic [jnc_pkg::COUNT_W-1:0]   max_bytes,
   input  logic [jnc_pkg::MAXD_W-1:0]    max_depth,
   input  logic                          top_kind,
   output jnc_pkg::stack_op_type         op,
   output jnc_pkg::result_type           result
);

   logic                          in_string_ff, in_string_in;
   logic                          escape_ff, escape_in;
   logic [jnc_pkg::DEPTH_W-1:0]   depth_ff, depth_in;
   logic [jnc_pkg::COUNT_W-1:0]   count_ff, count_in;
   jnc_pkg::err_type              err_ff, err_in;

   logic [jnc_pkg::LIM_W-1:0]     limit;
   logic [jnc_pkg::DEPTH_W-1:0]   depth_scan;
   logic                          in_string_scan;
   logic                          escape_scan;
   jnc_pkg::err_type              err_scan;
   logic [jnc_pkg::COUNT_W-1:0]   count_step;
   logic                          is_open;
   logic                          is_close;
   logic                          want_kind;

   // Depth limit clamped to the stack size
   always_comb begin
      if (jnc_pkg::LIM_W'(max_depth) > jnc_pkg::LIM_W'(jnc_pkg::STACK_DEPTH)) begin
         limit = jnc_pkg::LIM_W'(jnc_pkg::STACK_DEPTH);
      end else begin
         limit = jnc_pkg::LIM_W'(max_depth);
      end
   end

   assign is_open   = (data_byte == jnc_pkg::CH_LBRACE) || (data_byte == jnc_pkg::CH_LBRACK);
   assign is_close  = (data_byte == jnc_pkg::CH_RBRACE) || (data_byte == jnc_pkg::CH_RBRACK);
   assign want_kind = (data_byte == jnc_pkg::CH_RBRACK) ? jnc_pkg::KIND_BRACK
                                                        : jnc_pkg::KIND_BRACE;

   // Byte scan; frozen once an error is latched
   always_comb begin
      in_string_scan = in_string_ff;
      escape_scan    = escape_ff;
      depth_scan     = depth_ff;
      err_scan       = err_ff;
      op             = '0;
      op.kind        = (data_byte == jnc_pkg::CH_LBRACK) ? jnc_pkg::KIND_BRACK
                                                         : jnc_pkg::KIND_BRACE;
      if (err_ff == jnc_pkg::ERR_NONE) begin
         if (in_string_ff) begin
            if (escape_ff) begin
               escape_scan = 1'b0;
            end else if (data_byte == jnc_pkg::CH_BSLASH) begin
               escape_scan = 1'b1;
            end else if (data_byte == jnc_pkg::CH_QUOTE) begin
               in_string_scan = 1'b0;
            end
         end else if (data_byte == jnc_pkg::CH_QUOTE) begin
            in_string_scan = 1'b1;
         end else if (is_open) begin
            if (jnc_pkg::LIM_W'(depth_ff) >= limit) begin
               err_scan = jnc_pkg::ERR_DEEP;
            end else begin
               depth_scan = depth_ff + 1'b1;
               op.push    = accept;
            end
         end else if (is_close) begin
            if ((depth_ff == '0) || (top_kind != want_kind)) begin
               err_scan = jnc_pkg::ERR_MISMATCH;
            end else begin
               depth_scan = depth_ff - 1'b1;
               op.pop     = accept;
            end
         end
      end
   end

   assign count_step = (count_ff == jnc_pkg::COUNT_MAX) ? count_ff : count_ff + 1'b1;

   // Result item for this byte
   always_comb begin
      result.done_res   = last_byte;
      result.error_seen = (err_scan != jnc_pkg::ERR_NONE);
      result.open_count = jnc_pkg::OPEN_W'(depth_scan);
      result.verdict    = jnc_pkg::VERDICT_OK;
      if (last_byte) begin
         if (count_step > max_bytes) begin
            result.verdict = jnc_pkg::VERDICT_TOO_BIG;
         end else if (err_scan == jnc_pkg::ERR_DEEP) begin
            result.verdict = jnc_pkg::VERDICT_TOO_DEEP;
         end else if (err_scan == jnc_pkg::ERR_MISMATCH) begin
            result.verdict = jnc_pkg::VERDICT_MISMATCH;
         end else if (in_string_scan || (depth_scan != '0)) begin
            result.verdict = jnc_pkg::VERDICT_UNTERM;
         end
      end
   end

   // Next state: document clears after its last byte
   always_comb begin
      in_string_in = in_string_ff;
      escape_in    = escape_ff;
      depth_in     = depth_ff;
      count_in     = count_ff;
      err_in       = err_ff;
      if (accept) begin
         if (last_byte) begin
            in_string_in = 1'b0;
            escape_in    = 1'b0;
            depth_in     = '0;
            count_in     = '0;
            err_in       = jnc_pkg::ERR_NONE;
         end else begin
            in_string_in = in_string_scan;
            escape_in    = escape_scan;
            depth_in     = depth_scan;
            count_in     = count_step;
            err_in       = err_scan;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_string_ff <= 1'b0;
         escape_ff    <= 1'b0;
         depth_ff     <= '0;
         count_ff     <= '0;
         err_ff       <= jnc_pkg::ERR_NONE;
      end else begin
         in_string_ff <= in_string_in;
         escape_ff    <= escape_in;
         depth_ff     <= depth_in;
         count_ff     <= count_in;
         err_ff       <= err_in;
      end
   end

endmodule

### rtl/json_nesting_checker_unit.sv
`timescale 1ns / 1ps

// JSON nesting checker.
// req_chan carries one document byte per item, with last_byte set on the
// final byte of a document. rsp_chan returns exactly one item per byte:
// the open container count and error flag after that byte, and on the
// last byte the document verdict (ok, too large, too deep, mismatched
// delimiter, unterminated). Quoted bytes and escapes are skipped.
// The result item appears in the output register on the cycle after its
// byte is accepted. Throughput is one byte per cycle while the receiver
// takes results, set by the update of the scan state and the top stack cell;
// the stack is a row of cells that shift down on a push and up on a pop.
// req_chan.ready stays high while the output register is empty or being
// taken; if the receiver stalls, one result is held and input stops until
// it is taken. csr_write_enable writes max_bytes (index 0) or max_depth
// (index 1); write only while idle.
// Reset (synchronous) clears the document state and the output register and
// restores max_bytes to 1048576 and max_depth to 32.
module json_nesting_checker_unit (
   input  logic                              clock,
   input  logic                              reset,
   jnc_req_if.sink                           req_chan,
   jnc_rsp_if.source                         rsp_chan,
   input  logic                              csr_write_enable,
   input  logic [jnc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [jnc_pkg::CSR_DATA_W-1:0]    csr_write_data
);

   logic [jnc_pkg::COUNT_W-1:0] max_bytes_ff;
   logic [jnc_pkg::MAXD_W-1:0]  max_depth_ff;
   logic                        out_valid_ff, out_valid_in;
   jnc_pkg::result_type         out_data_ff;
   jnc_pkg::result_type         result;
   jnc_pkg::stack_op_type       op;
   logic                        accept;
   logic [jnc_pkg::STACK_DEPTH-1:0] kinds;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         max_bytes_ff <= jnc_pkg::MAX_BYTES_RST;
         max_depth_ff <= jnc_pkg::MAX_DEPTH_RST;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            jnc_pkg::CSR_MAX_BYTES: max_bytes_ff <= csr_write_data[jnc_pkg::COUNT_W-1:0];
            jnc_pkg::CSR_MAX_DEPTH: max_depth_ff <= csr_write_data[jnc_pkg::MAXD_W-1:0];
            default: ;
         endcase
      end
   end

   assign req_chan.ready = !out_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   jnc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .data_byte (req_chan.data_byte),
      .last_byte (req_chan.last_byte),
      .max_bytes (max_bytes_ff),
      .max_depth (max_depth_ff),
      .top_kind  (kinds[0]),
      .op        (op),
      .result    (result)
   );

   // Stack cells: cell 0 is the top of stack
   for (genvar i = 0; i < jnc_pkg::STACK_DEPTH; i++) begin : g_cell
      logic upper;
      logic lower;
      if (i == 0) begin : g_top
         assign upper = op.kind;
      end else begin : g_mid
         assign upper = kinds[i-1];
      end
      if (i == jnc_pkg::STACK_DEPTH - 1) begin : g_bot
         assign lower = jnc_pkg::KIND_BRACE;
      end else begin : g_up
         assign lower = kinds[i+1];
      end
      jnc_cell u_cell (
         .clock      (clock),
         .op         (op),
         .from_upper (upper),
         .from_lower (lower),
         .kind       (kinds[i])
      );
   end

   // Output register
   always_comb begin
      out_valid_in = out_valid_ff;
      if (accept) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         out_data_ff <= result;
      end
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.done_res   = out_data_ff.done_res;
   assign rsp_chan.verdict    = out_data_ff.verdict;
   assign rsp_chan.error_seen = out_data_ff.error_seen;
   assign rsp_chan.open_count = out_data_ff.open_count;

endmodule

### rtl/jnc_checker.sv
`timescale 1ns / 1ps

module jnc_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic                       rsp_done_res,
   input logic [2:0]                 rsp_verdict,
   input logic                       rsp_error_seen,
   input logic [jnc_pkg::OPEN_W-1:0] rsp_open_count
);

   // Output register is empty after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A stalled result holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_done_res) &&
      $stable(rsp_verdict) && $stable(rsp_error_seen) && $stable(rsp_open_count))
      else $error("stalled result changed");

   // Input is taken whenever the output slot is free
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input blocked with empty output");

   // Only a verdict item carries a nonzero verdict
   a_verdict_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_done_res |-> rsp_verdict == jnc_pkg::VERDICT_OK)
      else $error("verdict on non-final item");

   // An ok document has no open containers and no latched error
   a_ok_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res && rsp_verdict == jnc_pkg::VERDICT_OK |->
      rsp_open_count == '0 && !rsp_error_seen)
      else $error("ok verdict with open containers or error");

endmodule

bind json_nesting_checker_unit jnc_checker u_jnc_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_done_res   (rsp_chan.done_res),
   .rsp_verdict    (rsp_chan.verdict),
   .rsp_error_seen (rsp_chan.error_seen),
   .rsp_open_count (rsp_chan.open_count)
);
